[src/rctk_pkg.sv]
// Package for the route candidate top-K filter.
// Holds the request, result and buffer entry types, the codes and the buffer sizing.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rctk_pkg;

  localparam int unsigned BufDepth = 8;
  localparam int unsigned IdxW = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam int unsigned CntW = $clog2(BufDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(BufDepth);

  localparam logic [23:0] MarginReset = 24'd5000;
  localparam logic [23:0] DistMax = 24'hFFFFFF;

  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqSegment = 2'd1;
  localparam logic [1:0] ReqFinish = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatNoSegment = 2'd1;
  localparam logic [1:0] StatNoLocalMin = 2'd2;
  localparam logic [1:0] StatNoValid = 2'd3;

  localparam logic AluCmp = 1'b0;
  localparam logic AluAdd = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [23:0] xtrack_cm;
    logic        at_start;
    logic        at_end;
    logic        is_loop;
    logic        is_first_segment;
    logic        is_last_segment;
    logic        zero_length;
    logic        candidate_ok;
    logic [15:0] seg_start_index;
    logic [15:0] seg_end_index;
    logic [27:0] route_along_cm;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_status;
    logic [2:0]  rank;
    logic [23:0] entry_xtrack_cm;
    logic [15:0] entry_start_index;
    logic [15:0] entry_end_index;
    logic [27:0] entry_route_along_cm;
    logic        entry_is_loop;
    logic        last_in_run;
  } res_t;

  typedef struct packed {
    logic [23:0] xtrack;
    logic [15:0] start_idx;
    logic [15:0] end_idx;
    logic [27:0] along;
    logic        is_loop;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } store_wr_t;

endpackage

`default_nettype wire

[src/rctk_alu.sv]
// Shared 24-bit adder of the filter: unsigned less-than compare or saturating add.
// Depends on rctk_pkg for the operation codes.
`default_nettype none

module rctk_alu (
  input  wire logic        op_i,
  input  wire logic [23:0] a_i,
  input  wire logic [23:0] b_i,
  output logic             lt_o,
  output logic [23:0]      sum_o
);

  logic [23:0] b_op;
  logic [24:0] raw;

  assign b_op = (op_i == rctk_pkg::AluCmp) ? ~b_i : b_i;
  assign raw = {1'b0, a_i} + {1'b0, b_op} + {24'd0, (op_i == rctk_pkg::AluCmp)};
  assign lt_o = ~raw[24];
  assign sum_o = raw[24] ? rctk_pkg::DistMax : raw[23:0];

endmodule

`default_nettype wire

[src/rctk_store.sv]
// Sorted candidate buffer storage: one write port and one read port.
// Depends on rctk_pkg for the entry type and the buffer depth.
`default_nettype none

module rctk_store (
  input  wire logic                       clk_i,
  input  wire rctk_pkg::store_wr_t        wr_i,
  input  wire logic [rctk_pkg::IdxW-1:0]  raddr_i,
  output rctk_pkg::entry_t                rdata_o
);

  rctk_pkg::entry_t mem_q [rctk_pkg::BufDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rdata_o = mem_q[raddr_i];

endmodule

`default_nettype wire

[src/route_candidate_topk_filter.sv]
// Top level of the route candidate top-K filter: sequencer, scan state and result register.
// Depends on rctk_pkg, rctk_alu and rctk_store.
//
// A request is taken when start is high and busy is low. A start request clears the scan
// at its accepting edge and never raises busy. A segment request returns to idle from the
// check state when it is skipped or rejected at the window check. Otherwise it goes on to
// the minimum compare and then, without a new minimum, to the insert walk, or with a new
// minimum to the window update, the prune and then the insert walk. The entries that the
// prune drops and those that the insert walk moves down together never exceed the number
// of buffered entries (at most 8). All steps share one 24-bit adder, which the sequencer
// uses once per cycle, so the buffer moves one entry a cycle. A finish request emits
// max(count, 1) results, one per cycle; each is on result_o for one cycle with
// result_valid_o high, the first registered in the emit state that the accepting edge
// enters, and the last one carries last_in_run. The receiver cannot stall the results.
// The user must write the window margin register through cfg_we_i and cfg_wdata_i only
// while busy is low; the block itself does not enforce it. Reset clears the scan state
// and sets the margin to 5000 cm.
`default_nettype none

module route_candidate_topk_filter (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire rctk_pkg::req_t  req_i,
  output logic                 result_valid_o,
  output rctk_pkg::res_t       result_o,
  input  wire logic            cfg_we_i,
  input  wire logic [23:0]     cfg_wdata_i
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SMin = 3'd2;
  localparam logic [2:0] SWin = 3'd3;
  localparam logic [2:0] SPrune = 3'd4;
  localparam logic [2:0] SIns = 3'd5;
  localparam logic [2:0] SEmit = 3'd6;

  logic [2:0] state_q, state_d;
  rctk_pkg::req_t req_q, req_d;
  logic [rctk_pkg::CntW-1:0] count_q, count_d;
  logic [rctk_pkg::CntW-1:0] ptr_q, ptr_d;
  logic [23:0] min_q, min_d;
  logic [23:0] limit_q, limit_d;
  logic [23:0] margin_q;
  logic prev_end_q, prev_end_d;
  logic seen_seg_q, seen_seg_d;
  logic seen_lm_q, seen_lm_d;
  logic seen_valid_q, seen_valid_d;
  logic res_valid_q, res_valid_d;
  rctk_pkg::res_t res_q, res_d;

  logic alu_op;
  logic [23:0] alu_a, alu_b, alu_sum;
  logic alu_lt;
  logic [rctk_pkg::CntW-1:0] rd_ptr;
  rctk_pkg::entry_t rd_entry, new_entry;
  rctk_pkg::store_wr_t wr;
  logic skip, corner, local_min, ptr_full, emit_last;

  rctk_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lt_o  (alu_lt),
    .sum_o (alu_sum)
  );

  rctk_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (rd_ptr[rctk_pkg::IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  assign busy = (state_q != SIdle);
  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

  assign new_entry = '{xtrack: req_q.xtrack_cm, start_idx: req_q.seg_start_index,
                       end_idx: req_q.seg_end_index, along: req_q.route_along_cm,
                       is_loop: req_q.is_loop};

  assign skip = req_q.zero_length && !req_q.is_last_segment && !req_q.is_first_segment;
  assign corner = req_q.at_start || req_q.at_end;
  assign local_min = req_q.is_loop ? !corner :
                     ((req_q.is_last_segment && req_q.at_end) || !corner ||
                      (req_q.at_start && prev_end_q));
  assign ptr_full = (ptr_q == rctk_pkg::DepthCnt);
  assign emit_last = ((ptr_q + rctk_pkg::CntW'(1)) == count_q);

  always_comb begin
    case (state_q)
      SPrune: rd_ptr = count_q - rctk_pkg::CntW'(1);
      SIns: rd_ptr = ptr_q - rctk_pkg::CntW'(1);
      default: rd_ptr = ptr_q;
    endcase
  end

  always_comb begin
    alu_op = rctk_pkg::AluCmp;
    alu_a = req_q.xtrack_cm;
    alu_b = limit_q;
    case (state_q)
      SMin: alu_b = min_q;
      SWin: begin
        alu_op = rctk_pkg::AluAdd;
        alu_b = margin_q;
      end
      SPrune: begin
        alu_a = limit_q;
        alu_b = rd_entry.xtrack;
      end
      SIns: alu_b = rd_entry.xtrack;
      default: alu_b = limit_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    count_d = count_q;
    ptr_d = ptr_q;
    min_d = min_q;
    limit_d = limit_q;
    prev_end_d = prev_end_q;
    seen_seg_d = seen_seg_q;
    seen_lm_d = seen_lm_q;
    seen_valid_d = seen_valid_q;
    res_valid_d = 1'b0;
    res_d = res_q;
    wr.we = 1'b0;
    wr.addr = ptr_q[rctk_pkg::IdxW-1:0];
    wr.data = new_entry;
    case (state_q)
      SIdle: begin
        if (start) begin
          case (req_i.req_type)
            rctk_pkg::ReqStart: begin
              count_d = '0;
              min_d = rctk_pkg::DistMax;
              limit_d = rctk_pkg::DistMax;
              prev_end_d = 1'b0;
              seen_seg_d = 1'b0;
              seen_lm_d = 1'b0;
              seen_valid_d = 1'b0;
            end
            rctk_pkg::ReqSegment: begin
              req_d = req_i;
              state_d = SCheck;
            end
            rctk_pkg::ReqFinish: begin
              ptr_d = '0;
              state_d = SEmit;
            end
            default: state_d = SIdle;
          endcase
        end
      end
      SCheck: begin
        seen_seg_d = 1'b1;
        state_d = SIdle;
        if (!skip) begin
          if (local_min) begin
            seen_lm_d = 1'b1;
          end
          if (!req_q.is_loop) begin
            prev_end_d = req_q.zero_length ? 1'b0 : req_q.at_end;
          end
          if (local_min && req_q.candidate_ok && alu_lt) begin
            seen_valid_d = 1'b1;
            state_d = SMin;
          end
        end
      end
      SMin: begin
        if (alu_lt) begin
          min_d = req_q.xtrack_cm;
          state_d = SWin;
        end else begin
          ptr_d = count_q;
          state_d = SIns;
        end
      end
      SWin: begin
        limit_d = alu_sum;
        state_d = SPrune;
      end
      SPrune: begin
        if ((count_q != '0) && alu_lt) begin
          count_d = count_q - rctk_pkg::CntW'(1);
        end else begin
          ptr_d = count_q;
          state_d = SIns;
        end
      end
      SIns: begin
        if ((ptr_q != '0) && alu_lt) begin
          if (!ptr_full) begin
            wr.we = 1'b1;
            wr.data = rd_entry;
          end
          ptr_d = ptr_q - rctk_pkg::CntW'(1);
        end else begin
          if (!ptr_full) begin
            wr.we = 1'b1;
            count_d = (count_q == rctk_pkg::DepthCnt) ? count_q :
                      count_q + rctk_pkg::CntW'(1);
          end
          state_d = SIdle;
        end
      end
      SEmit: begin
        res_valid_d = 1'b1;
        if (count_q == '0) begin
          res_d = '0;
          res_d.result_status = !seen_seg_q ? rctk_pkg::StatNoSegment :
                                (!seen_lm_q ? rctk_pkg::StatNoLocalMin :
                                 rctk_pkg::StatNoValid);
          res_d.last_in_run = 1'b1;
          state_d = SIdle;
        end else begin
          res_d.result_status = rctk_pkg::StatOk;
          res_d.rank = 3'(ptr_q);
          res_d.entry_xtrack_cm = rd_entry.xtrack;
          res_d.entry_start_index = rd_entry.start_idx;
          res_d.entry_end_index = rd_entry.end_idx;
          res_d.entry_route_along_cm = rd_entry.along;
          res_d.entry_is_loop = rd_entry.is_loop;
          res_d.last_in_run = emit_last;
          ptr_d = ptr_q + rctk_pkg::CntW'(1);
          if (emit_last) begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      ptr_q <= '0;
      min_q <= rctk_pkg::DistMax;
      limit_q <= rctk_pkg::DistMax;
      margin_q <= rctk_pkg::MarginReset;
      prev_end_q <= 1'b0;
      seen_seg_q <= 1'b0;
      seen_lm_q <= 1'b0;
      seen_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q <= ptr_d;
      min_q <= min_d;
      limit_q <= limit_d;
      prev_end_q <= prev_end_d;
      seen_seg_q <= seen_seg_d;
      seen_lm_q <= seen_lm_d;
      seen_valid_q <= seen_valid_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        margin_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  // The buffer never holds more entries than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= rctk_pkg::DepthCnt)
    else $error("buffer count above depth");

  // The window limit never falls below the best distance seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni) limit_q >= min_q)
    else $error("window limit below minimum distance");

  // Only the final result of a run may appear after the sequencer went idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_in_run |-> busy)
    else $error("non-final result outside a finish run");

  // A start request leaves an empty buffer and an idle sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.req_type == rctk_pkg::ReqStart) |=>
    (count_q == '0) && !busy)
    else $error("start request did not clear the scan");

endmodule

`default_nettype wire
